>>> rtl/lfpd_pkg.sv
`default_nettype none
package lfpd_pkg;

    localparam int unsigned ErrW   = 8;
    localparam int unsigned SumW   = 16;
    localparam int unsigned DrvW   = 13;
    localparam int unsigned GainW  = 16;
    localparam int unsigned SpdW   = 12;
    localparam int unsigned RatioW = 8;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgDatW = 16;
    localparam int unsigned AvgW   = 25;
    localparam int unsigned DivW   = 24;

    localparam logic [6:0] LOST_LINE_LIMIT = 7'd100;

    localparam logic [1:0] MODE_FIND  = 2'd0;
    localparam logic [1:0] MODE_TRACK = 2'd1;
    localparam logic [1:0] MODE_IDLE  = 2'd2;

    localparam logic [CfgIdxW-1:0] REG_KP    = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_KD    = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_FAST  = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_CURVE = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_RATIO = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_DIFFD = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_TRACK = 3'd6;

    typedef struct packed {
        logic                     pd;
        logic                     valid;
        logic signed [DrvW-1:0]   left;
        logic signed [DrvW-1:0]   right;
        logic [1:0]               mode;
        logic signed [SumW-1:0]   err_sum;
        logic signed [SumW-1:0]   diff_sum;
        logic signed [DrvW-1:0]   base;
    } cmd_t;

endpackage
`default_nettype wire

>>> rtl/line_follow_pd_speed_control.sv
// Path: a sample needing no drive computation goes from the queue into the output register.
// A control update with PD drive runs two 24-step shift-subtract divisions (one bit a cycle),
// two gain multiplies, one sum and the output load, which waits while the output is held.
// Throughput: one sample a cycle while the queue is not full; one PD update at a time in the back end.
// Reset: asynchronous active-low rst_n clears control state and loads register defaults.
`default_nettype none
module line_follow_pd_speed_control
    import lfpd_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic signed [ErrW-1:0]   err_sample,
    input  wire logic                     all_white,
    input  wire logic                     all_black,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [CfgIdxW-1:0]       cfg_index,
    input  wire logic [CfgDatW-1:0]       cfg_data,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic                          drive_valid,
    output logic signed [DrvW-1:0]        left_drive,
    output logic signed [DrvW-1:0]        right_drive,
    output logic [1:0]                    run_mode
);

    logic signed [GainW-1:0] kp_reg;
    logic signed [GainW-1:0] kd_reg;
    logic [SpdW-1:0]         fast_reg;
    logic [SpdW-1:0]         curve_reg;
    logic [RatioW-1:0]       ratio_reg;
    logic [RatioW-1:0]       diffd_reg;
    logic                    track_reg;

    cmd_t push_cmd;
    cmd_t head;
    logic full;
    logic empty;
    logic pop;
    logic accept;

    assign cfg_ready = 1'b1;
    assign in_ready  = !full;
    assign accept    = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg    <= 16'sd7680;
            kd_reg    <= 16'sd1485;
            fast_reg  <= 12'd500;
            curve_reg <= 12'd300;
            ratio_reg <= 8'd1;
            diffd_reg <= 8'd2;
            track_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_KP:    kp_reg    <= cfg_data;
                REG_KD:    kd_reg    <= cfg_data;
                REG_FAST:  fast_reg  <= cfg_data[SpdW-1:0];
                REG_CURVE: curve_reg <= cfg_data[SpdW-1:0];
                REG_RATIO: ratio_reg <= cfg_data[RatioW-1:0];
                REG_DIFFD: diffd_reg <= cfg_data[RatioW-1:0];
                REG_TRACK: track_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    lfpd_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .accept           (accept),
        .err_sample       (err_sample),
        .all_white        (all_white),
        .all_black        (all_black),
        .speed_fast       (fast_reg),
        .speed_curve      (curve_reg),
        .decimation_ratio (ratio_reg),
        .tracking_allowed (track_reg),
        .cmd              (push_cmd)
    );

    lfpd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (accept),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .full     (full),
        .empty    (empty)
    );

    lfpd_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .head             (head),
        .empty            (empty),
        .pop              (pop),
        .kp_gain          (kp_reg),
        .kd_gain          (kd_reg),
        .decimation_ratio (ratio_reg),
        .diff_divisor     (diffd_reg),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .drive_valid      (drive_valid),
        .left_drive       (left_drive),
        .right_drive      (right_drive),
        .run_mode         (run_mode)
    );

endmodule
`default_nettype wire

>>> rtl/lfpd_queue.sv
`default_nettype none
module lfpd_queue
    import lfpd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  cmd_t      push_cmd,
    input  wire logic pop,
    output cmd_t      head,
    output logic      full,
    output logic      empty
);

    cmd_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    assign head  = mem_reg[rd_ptr_reg];
    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);

endmodule
`default_nettype wire

>>> rtl/lfpd_front.sv
`default_nettype none
module lfpd_front
    import lfpd_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     accept,
    input  wire logic signed [ErrW-1:0]   err_sample,
    input  wire logic                     all_white,
    input  wire logic                     all_black,
    input  wire logic [SpdW-1:0]          speed_fast,
    input  wire logic [SpdW-1:0]          speed_curve,
    input  wire logic [RatioW-1:0]        decimation_ratio,
    input  wire logic                     tracking_allowed,
    output cmd_t                          cmd
);

    logic signed [ErrW-1:0] prev_err_reg, prev_err_next;
    logic signed [SumW-1:0] err_sum_reg, err_sum_next;
    logic signed [SumW-1:0] diff_sum_reg, diff_sum_next;
    logic [RatioW-1:0]      sample_count_reg, sample_count_next;
    logic [8:0]             straight_count_reg, straight_count_next;
    logic [6:0]             lost_count_reg, lost_count_next;
    logic signed [DrvW-1:0] base_speed_reg, base_speed_next;
    logic [1:0]             mode_reg, mode_next;
    logic                   mark_seen_reg, mark_seen_next;

    logic signed [SumW+1:0] err_acc;
    logic signed [SumW+1:0] diff_acc;
    logic signed [SumW-1:0] err_sat;
    logic signed [SumW-1:0] diff_sat;
    logic [8:0]             next_cnt;

    always_comb
    begin
        prev_err_next       = prev_err_reg;
        err_sum_next        = err_sum_reg;
        diff_sum_next       = diff_sum_reg;
        sample_count_next   = sample_count_reg;
        straight_count_next = straight_count_reg;
        lost_count_next     = lost_count_reg;
        base_speed_next     = base_speed_reg;
        mode_next           = mode_reg;
        mark_seen_next      = mark_seen_reg;

        err_acc  = '0;
        diff_acc = '0;
        err_sat  = '0;
        diff_sat = '0;
        next_cnt = {1'b0, sample_count_reg} + 9'd1;

        cmd          = '0;
        cmd.mode     = mode_reg;

        if (all_white && mode_reg == MODE_TRACK && lost_count_reg > LOST_LINE_LIMIT)
        begin
            cmd.valid = 1'b1;
            cmd.left  = -13'sd300;
            cmd.right = -13'sd300;
        end
        else
        begin
            if (all_white && mode_reg == MODE_TRACK)
            begin
                if (lost_count_reg != 7'd127)
                begin
                    lost_count_next = lost_count_reg + 7'd1;
                end
            end
            else
            begin
                lost_count_next = '0;
            end

            diff_acc = 18'(diff_sum_reg) + 18'(err_sample) - 18'(prev_err_reg);
            err_acc  = 18'(err_sum_reg) + 18'(err_sample);
            if (diff_acc > 18'sd32767)
                diff_sat = 16'sh7FFF;
            else if (diff_acc < -18'sd32768)
                diff_sat = 16'sh8000;
            else
                diff_sat = diff_acc[SumW-1:0];
            if (err_acc > 18'sd32767)
                err_sat = 16'sh7FFF;
            else if (err_acc < -18'sd32768)
                err_sat = 16'sh8000;
            else
                err_sat = err_acc[SumW-1:0];

            prev_err_next = err_sample;
            diff_sum_next = diff_sat;
            err_sum_next  = err_sat;

            if (next_cnt == {1'b0, decimation_ratio} && tracking_allowed)
            begin
                sample_count_next = '0;
                if (err_sample == '0)
                begin
                    if (straight_count_reg > 9'd300)
                    begin
                        base_speed_next = DrvW'({1'b0, speed_fast});
                    end
                    else if (straight_count_reg > 9'd200)
                    begin
                        base_speed_next = DrvW'({1'b0, speed_fast}) - 13'sd100;
                        straight_count_next = straight_count_reg + 9'd1;
                    end
                    else
                    begin
                        straight_count_next = straight_count_reg + 9'd1;
                    end
                end
                else
                begin
                    if (straight_count_reg > 9'd200)
                        base_speed_next = -13'sd600;
                    else if (straight_count_reg > 9'd100)
                        base_speed_next = -13'sd400;
                    else
                        base_speed_next = DrvW'({1'b0, speed_curve});
                    straight_count_next = '0;
                end

                unique case (mode_reg)
                    MODE_FIND:
                    begin
                        if (all_black && !mark_seen_reg)
                        begin
                            mark_seen_next = 1'b1;
                        end
                        else if (!all_black && mark_seen_reg)
                        begin
                            mark_seen_next = 1'b0;
                            mode_next      = MODE_TRACK;
                        end
                    end
                    MODE_TRACK:
                    begin
                        cmd.valid = 1'b1;
                        if (all_black)
                        begin
                            mode_next = MODE_IDLE;
                        end
                        else
                        begin
                            cmd.pd = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase

                cmd.mode     = mode_next;
                cmd.err_sum  = err_sat;
                cmd.diff_sum = diff_sat;
                cmd.base     = base_speed_next;
                err_sum_next  = '0;
                diff_sum_next = '0;
            end
            else if (next_cnt > {1'b0, decimation_ratio})
            begin
                sample_count_next = '0;
            end
            else
            begin
                sample_count_next = next_cnt[RatioW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_err_reg       <= '0;
            err_sum_reg        <= '0;
            diff_sum_reg       <= '0;
            sample_count_reg   <= '0;
            straight_count_reg <= '0;
            lost_count_reg     <= '0;
            base_speed_reg     <= '0;
            mode_reg           <= MODE_FIND;
            mark_seen_reg      <= 1'b0;
        end
        else if (accept)
        begin
            prev_err_reg       <= prev_err_next;
            err_sum_reg        <= err_sum_next;
            diff_sum_reg       <= diff_sum_next;
            sample_count_reg   <= sample_count_next;
            straight_count_reg <= straight_count_next;
            lost_count_reg     <= lost_count_next;
            base_speed_reg     <= base_speed_next;
            mode_reg           <= mode_next;
            mark_seen_reg      <= mark_seen_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/lfpd_back.sv
`default_nettype none
module lfpd_back
    import lfpd_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  cmd_t                          head,
    input  wire logic                     empty,
    output logic                          pop,
    input  wire logic signed [GainW-1:0]  kp_gain,
    input  wire logic signed [GainW-1:0]  kd_gain,
    input  wire logic [RatioW-1:0]        decimation_ratio,
    input  wire logic [RatioW-1:0]        diff_divisor,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic                          drive_valid,
    output logic signed [DrvW-1:0]        left_drive,
    output logic signed [DrvW-1:0]        right_drive,
    output logic [1:0]                    run_mode
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_DIV_E, ST_DIV_D, ST_MUL_P, ST_MUL_D, ST_SUM, ST_DONE
    } state_t;

    state_t                   state_reg;
    logic [4:0]               cnt_reg;
    logic [DivW-1:0]          dvd_reg;
    logic [8:0]               rem_reg;
    logic                     neg_reg;
    logic signed [SumW-1:0]   dsum_reg;
    logic signed [DrvW-1:0]   base_reg;
    logic [1:0]               mode_reg;
    logic signed [AvgW-1:0]   ea_reg;
    logic signed [AvgW-1:0]   da_reg;
    logic signed [40:0]       pk_reg;
    logic signed [40:0]       pd_reg;
    logic signed [42:0]       s_reg;
    logic                     ov_reg;
    logic                     dv_reg;
    logic signed [DrvW-1:0]   l_reg;
    logic signed [DrvW-1:0]   r_reg;
    logic [1:0]               rm_reg;

    logic                     out_free;
    logic [8:0]               trial;
    logic                     qbit;
    logic [8:0]               rem_step;
    logic [RatioW-1:0]        divisor;
    logic [DivW-1:0]          quo_full;
    logic signed [AvgW-1:0]   quo_signed;
    logic [SumW-1:0]          dsum_mag;
    logic signed [42:0]       base_sh;
    logic signed [42:0]       s_left;
    logic signed [42:0]       s_right;
    logic signed [25:0]       q_left;
    logic signed [25:0]       q_right;
    logic signed [DrvW-1:0]   sat_left;
    logic signed [DrvW-1:0]   sat_right;

    function automatic logic signed [25:0] trunc_shift(input logic signed [42:0] v);
        logic signed [42:0] t;
        t = v + (v[42] ? 43'sd131071 : 43'sd0);
        return t[42:17];
    endfunction

    function automatic logic signed [DrvW-1:0] sat13(input logic signed [25:0] v);
        if (v > 26'sd4095)
            return 13'sd4095;
        else if (v < -26'sd4096)
            return -13'sd4096;
        else
            return v[DrvW-1:0];
    endfunction

    assign out_free = !ov_reg || out_ready;
    assign pop      = (state_reg == ST_IDLE) && !empty && (head.pd || out_free);

    always_comb
    begin
        divisor = (state_reg == ST_DIV_E) ? decimation_ratio
                : ((diff_divisor == '0) ? 8'd1 : diff_divisor);
        trial   = {rem_reg[7:0], dvd_reg[DivW-1]};
        qbit    = (trial >= {1'b0, divisor});
        rem_step = qbit ? (trial - {1'b0, divisor}) : trial;
        quo_full = {dvd_reg[DivW-2:0], qbit};
        quo_signed = neg_reg ? -$signed({1'b0, quo_full}) : $signed({1'b0, quo_full});
        dsum_mag = dsum_reg[SumW-1] ? SumW'(-dsum_reg) : dsum_reg;
        base_sh  = 43'(base_reg) <<< 17;
        s_left   = s_reg;
        s_right  = (base_sh <<< 1) - s_reg;
        q_left   = trunc_shift(s_left);
        q_right  = trunc_shift(s_right);
        sat_left  = sat13(q_left);
        sat_right = sat13(q_right);
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (pop && head.pd)
                begin
                    dvd_reg  <= {(head.err_sum[SumW-1] ? SumW'(-head.err_sum)
                                                       : head.err_sum), 8'd0};
                    neg_reg  <= head.err_sum[SumW-1];
                    rem_reg  <= '0;
                    dsum_reg <= head.diff_sum;
                    base_reg <= head.base;
                    mode_reg <= head.mode;
                end
            end
            ST_DIV_E, ST_DIV_D:
            begin
                dvd_reg <= quo_full;
                rem_reg <= rem_step;
                if (cnt_reg == 5'(DivW - 1))
                begin
                    if (state_reg == ST_DIV_E)
                    begin
                        ea_reg  <= quo_signed;
                        dvd_reg <= {dsum_mag, 8'd0};
                        neg_reg <= dsum_reg[SumW-1];
                        rem_reg <= '0;
                    end
                    else
                    begin
                        da_reg <= quo_signed;
                    end
                end
            end
            ST_MUL_P: pk_reg <= 41'(kp_gain) * 41'(ea_reg);
            ST_MUL_D: pd_reg <= 41'(kd_gain) * 41'(da_reg);
            ST_SUM:   s_reg  <= base_sh + 43'(pk_reg) + 43'(pd_reg);
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
            dv_reg    <= 1'b0;
            l_reg     <= '0;
            r_reg     <= '0;
            rm_reg    <= MODE_FIND;
        end
        else
        begin
            if (ov_reg && out_ready)
            begin
                ov_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    cnt_reg <= '0;
                    if (pop)
                    begin
                        if (head.pd)
                        begin
                            state_reg <= ST_DIV_E;
                        end
                        else
                        begin
                            ov_reg <= 1'b1;
                            dv_reg <= head.valid;
                            l_reg  <= head.left;
                            r_reg  <= head.right;
                            rm_reg <= head.mode;
                        end
                    end
                end
                ST_DIV_E, ST_DIV_D:
                begin
                    if (cnt_reg == 5'(DivW - 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= (state_reg == ST_DIV_E) ? ST_DIV_D : ST_MUL_P;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 5'd1;
                    end
                end
                ST_MUL_P: state_reg <= ST_MUL_D;
                ST_MUL_D: state_reg <= ST_SUM;
                ST_SUM:   state_reg <= ST_DONE;
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        ov_reg    <= 1'b1;
                        dv_reg    <= 1'b1;
                        l_reg     <= sat_left;
                        r_reg     <= sat_right;
                        rm_reg    <= mode_reg;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign out_valid   = ov_reg;
    assign drive_valid = dv_reg;
    assign left_drive  = l_reg;
    assign right_drive = r_reg;
    assign run_mode    = rm_reg;

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> state_reg == ST_IDLE)
        else $error("queue popped while busy");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV_E || state_reg == ST_DIV_D) |-> cnt_reg < 5'(DivW))
        else $error("divider step count out of range");

    a_done_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_free) |=> (ov_reg && dv_reg && state_reg == ST_IDLE))
        else $error("drive result not loaded");

    a_pd_track: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_free) |=> rm_reg == MODE_TRACK)
        else $error("drive computed outside tracking");

endmodule
`default_nettype wire
